// ===== rtl/mlpbw_pkg.sv =====
`default_nettype none

package mlpbw_pkg;

	// panel defaults
	localparam int WIDTH_DEF = 128;
	localparam int PAGES_DEF = 8;

	// panel command bytes
	localparam logic [7:0] CMD_SET_PAGE = 8'hb0;
	localparam logic [7:0] CMD_COL_HIGH = 8'h10;
	localparam logic [7:0] NIBBLE_MASK  = 8'h0f;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_COLUMNS = 2'd1;

	typedef struct packed {
		logic [7:0] bit_mask;
		logic [7:0] pixel_byte;
		logic [9:0] column;
		logic [6:0] page;
	} item_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       is_data;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PAGE,
		ST_COL_LO,
		ST_COL_HI,
		ST_DATA
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/masked_lcd_page_byte_writer.sv =====
`default_nettype none

// masked page-byte writer for a page-addressed monochrome panel
//
// command channel: an item (mask, data byte, column, page) is taken at a rising
// edge with start high and busy low. column and page saturate to the panel size.
// the block reads the frame byte at (column, page), merges in the masked bits,
// writes it back and plays out four beats on the result port, one per cycle:
// set-page, column-low, column-high and finally the merged data byte (last).
// each beat shows for exactly one cycle with result_valid high; the receiver
// cannot stall, so nothing here waits on it.
// the first beat appears the cycle after the accept edge, the data byte last.
// busy drops during the data beat, so a new item can be taken then; the item
// rate is set by the four serial bus beats.
// frame store: one synchronous ram, WIDTH*PAGES bytes, read at the accept edge,
// written back during the set-page beat, so the next item's read never overlaps.
// reset: state, counter and config registers clear; then, busy high, a clearing
// pass zeroes the ram one byte a cycle. config writes (cfg_valid/cfg_ready, always
// ready) are taken at any time and are meant to happen while idle.
module masked_lcd_page_byte_writer #(
	parameter int WIDTH = mlpbw_pkg::WIDTH_DEF,
	parameter int PAGES = mlpbw_pkg::PAGES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// item channel
	input  wire                               start,
	output logic                              busy,
	input  mlpbw_pkg::item_t                  item,
	// result channel
	output logic                              result_valid,
	output mlpbw_pkg::result_t                result,
	// configuration channel
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [mlpbw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [7:0]                         cfg_data
);

	localparam int DEPTH = WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(WIDTH);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

	// frame store
	logic [7:0] mem [DEPTH];

	mlpbw_pkg::state_t state_q, state_d;

	// configuration
	logic [6:0] column_offset_q;
	logic       mirror_q;

	// clearing pass
	logic [AW-1:0] clr_q;

	// per-item registers
	logic [AW-1:0] addr_q;
	logic [7:0]    mask_q;
	logic [7:0]    data_q;
	logic [7:0]    col_q;
	logic [3:0]    fpage_q;
	logic [7:0]    merged_q;
	logic [7:0]    rd_data_s1;

	logic          accept;
	logic [XW-1:0] x_cl;
	logic [PW-1:0] pg_cl;
	logic [AW-1:0] addr_in;
	logic [7:0]    col_base;
	logic [7:0]    col_in;
	logic [7:0]    merged;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// saturate coordinates and form the store address and panel column
	always_comb begin
		x_cl     = (item.column > 10'(WIDTH - 1)) ? XW'(WIDTH - 1) : XW'(item.column);
		pg_cl    = (item.page > 7'(PAGES - 1)) ? PW'(PAGES - 1) : PW'(item.page);
		addr_in  = AW'(AW'(x_cl) * AW'(PAGES) + AW'(pg_cl));
		col_base = mirror_q ? (8'(WIDTH - 1) - 8'(x_cl)) : 8'(x_cl);
		col_in   = col_base + {1'b0, column_offset_q};
	end

	// old bits outside the mask, new bits inside it
	assign merged = (rd_data_s1 & ~mask_q) | (data_q & mask_q);

	// sequencer: next state and beat outputs
	always_comb begin
		state_d      = state_q;
		busy         = 1'b1;
		result_valid = 1'b0;
		result       = '0;
		case (state_q)
			mlpbw_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = mlpbw_pkg::ST_IDLE;
				end
			end
			mlpbw_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (accept) begin
					state_d = mlpbw_pkg::ST_PAGE;
				end
			end
			mlpbw_pkg::ST_PAGE: begin
				result_valid    = 1'b1;
				result.bus_byte = mlpbw_pkg::CMD_SET_PAGE | {4'b0, fpage_q};
				state_d         = mlpbw_pkg::ST_COL_LO;
			end
			mlpbw_pkg::ST_COL_LO: begin
				result_valid    = 1'b1;
				result.bus_byte = col_q & mlpbw_pkg::NIBBLE_MASK;
				state_d         = mlpbw_pkg::ST_COL_HI;
			end
			mlpbw_pkg::ST_COL_HI: begin
				result_valid    = 1'b1;
				result.bus_byte = mlpbw_pkg::CMD_COL_HIGH | {4'b0, col_q[7:4]};
				state_d         = mlpbw_pkg::ST_DATA;
			end
			mlpbw_pkg::ST_DATA: begin
				busy            = 1'b0;
				result_valid    = 1'b1;
				result.bus_byte = merged_q;
				result.is_data  = 1'b1;
				result.last     = 1'b1;
				// back-to-back item: its read lands after this item's write-back
				state_d = accept ? mlpbw_pkg::ST_PAGE : mlpbw_pkg::ST_IDLE;
			end
			default: begin
				state_d = mlpbw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlpbw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == mlpbw_pkg::ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_offset_q <= '0;
			mirror_q        <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mlpbw_pkg::CFG_COLUMN_OFFSET: column_offset_q <= cfg_data[6:0];
				mlpbw_pkg::CFG_MIRROR_COLUMNS: mirror_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// item payload, captured at the accept edge; merged byte, during the set-page beat
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= addr_in;
			mask_q  <= item.bit_mask;
			data_q  <= item.pixel_byte;
			col_q   <= col_in;
			fpage_q <= 4'(PAGES - 1) - 4'(pg_cl);
		end
		if (state_q == mlpbw_pkg::ST_PAGE) begin
			merged_q <= merged;
		end
	end

	// ram read port
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= mem[addr_in];
		end
	end

	// ram write port: clearing pass or write-back
	always_ff @(posedge clk) begin
		if (state_q == mlpbw_pkg::ST_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (state_q == mlpbw_pkg::ST_PAGE) begin
			mem[addr_q] <= merged;
		end
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	// panel geometry as built into the block
	localparam int PANEL_W     = mlpbw_pkg::WIDTH_DEF;
	localparam int PANEL_PAGES = mlpbw_pkg::PAGES_DEF;
	localparam int STORE_DEPTH = PANEL_W * PANEL_PAGES;

	// register indexes past the end of the list, writes there must do nothing
	localparam logic [mlpbw_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [mlpbw_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// idle cycles with no accepted beat anywhere before the run is called hung;
	// covers the post-reset clearing pass plus the longest sender gap
	localparam int STALL_LIMIT = 4000;

	// cycles the block may still be playing out beats after the last one is due
	localparam int SETTLE_CYCLES = 4;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	mlpbw_pkg::item_t                item;
	logic                            result_valid;
	mlpbw_pkg::result_t              result;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [mlpbw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                      cfg_data;

	// shadow of the block's frame buffer and registers
	logic [7:0] frame_shadow [STORE_DEPTH];
	logic [6:0] offset_shadow;
	logic       mirror_shadow;

	// bus beats still owed by the block, oldest first
	mlpbw_pkg::result_t pending_beats [$];

	int         mismatches;
	int         stall_count;
	bit         no_idle;

	masked_lcd_page_byte_writer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// work out the four bus beats of one accepted write and update the shadow store
	task automatic predict_page_write(input mlpbw_pkg::item_t it);
		int                 xc;
		int                 pg;
		int                 col;
		int                 idx;
		logic [7:0]         merged;
		mlpbw_pkg::result_t beat;
		// saturate to the panel
		xc = (it.column > PANEL_W - 1) ? PANEL_W - 1 : int'(it.column);
		pg = (it.page > PANEL_PAGES - 1) ? PANEL_PAGES - 1 : int'(it.page);
		// panel column address is 8 bits, wraps mod 256
		col = mirror_shadow ? (PANEL_W - 1 - xc) : xc;
		col = (col + int'(offset_shadow)) & 'hff;
		// store is indexed by the clamped coordinates
		idx = xc * PANEL_PAGES + pg;
		merged = (frame_shadow[idx] & ~it.bit_mask) | (it.pixel_byte & it.bit_mask);
		frame_shadow[idx] = merged;
		// set-page, page number flipped for the panel
		beat.bus_byte = mlpbw_pkg::CMD_SET_PAGE |
			(8'(PANEL_PAGES - 1 - pg) & mlpbw_pkg::NIBBLE_MASK);
		beat.is_data = 1'b0;
		beat.last = 1'b0;
		pending_beats.push_back(beat);
		// column low nibble
		beat.bus_byte = 8'(col) & mlpbw_pkg::NIBBLE_MASK;
		pending_beats.push_back(beat);
		// column high nibble
		beat.bus_byte = mlpbw_pkg::CMD_COL_HIGH | ((8'(col) >> 4) & mlpbw_pkg::NIBBLE_MASK);
		pending_beats.push_back(beat);
		// merged display byte closes the run
		beat.bus_byte = merged;
		beat.is_data = 1'b1;
		beat.last = 1'b1;
		pending_beats.push_back(beat);
	endtask

	// present one write on the command channel after a random gap, wait for acceptance
	task automatic send_item(input mlpbw_pkg::item_t it);
		int unsigned gap;
		int unsigned roll;
		gap = 0;
		if (!no_idle) begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				gap = 0;
			else if (roll < 90)
				gap = $urandom_range(1, 4);
			else
				gap = $urandom_range(5, 40);
		end
		// start was dropped at the last accept edge, so always move one edge on
		@(posedge clk);
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy !== 1'b0);
		predict_page_write(it);
		start <= 1'b0;
	endtask

	// wait until every owed beat has come and the block is back at rest
	task automatic wait_quiet();
		while (pending_beats.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one beat on the configuration channel, only called while the block is quiet
	task automatic write_reg(input logic [mlpbw_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			mlpbw_pkg::CFG_COLUMN_OFFSET:  offset_shadow = data[6:0];
			mlpbw_pkg::CFG_MIRROR_COLUMNS: mirror_shadow = data[0];
			default: ;
		endcase
		// step off this edge so a following beat drives on a fresh one
		@(posedge clk);
	endtask

	// mostly on-panel coordinates, some saturating, some piled onto a few hot bytes
	function automatic mlpbw_pkg::item_t random_item();
		mlpbw_pkg::item_t it;
		int unsigned      roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			it.bit_mask = 8'h00;
		else if (roll == 1)
			it.bit_mask = 8'hff;
		else
			it.bit_mask = 8'($urandom);
		it.pixel_byte = 8'($urandom);
		roll = $urandom_range(0, 9);
		if (roll < 3) begin
			// hot corner so masked merges stack up on the same byte
			it.column = 10'($urandom_range(0, 3));
			it.page = 7'($urandom_range(0, 1));
		end else if (roll < 8) begin
			it.column = 10'($urandom_range(0, PANEL_W - 1));
			it.page = 7'($urandom_range(0, PANEL_PAGES - 1));
		end else begin
			it.column = 10'($urandom_range(0, 1023));
			it.page = 7'($urandom_range(0, 127));
		end
		return it;
	endfunction

	// register defaults, field extremes, saturation, largest column offset
	task automatic test_directed_corners();
		// reset settings: no offset, no mirror
		send_item(mlpbw_pkg::item_t'{8'hff, 8'ha5, 10'd0, 7'd0});
		send_item(mlpbw_pkg::item_t'{8'h0f, 8'hff, 10'd0, 7'd0});
		send_item(mlpbw_pkg::item_t'{8'h00, 8'hff, 10'd0, 7'd0});
		send_item(mlpbw_pkg::item_t'{8'hf0, 8'h00, 10'd0, 7'd0});
		send_item(mlpbw_pkg::item_t'{8'hff, 8'hff, 10'd127, 7'd7});
		send_item(mlpbw_pkg::item_t'{8'haa, 8'h55, 10'd128, 7'd8});
		send_item(mlpbw_pkg::item_t'{8'h55, 8'hff, 10'd1023, 7'd127});
		send_item(mlpbw_pkg::item_t'{8'hff, 8'h3c, 10'd64, 7'd3});
		// column saturates, page in range
		send_item(mlpbw_pkg::item_t'{8'hff, 8'h00, 10'd1023, 7'd0});
		// page saturates, column in range
		send_item(mlpbw_pkg::item_t'{8'h80, 8'h80, 10'd5, 7'd127});
		wait_quiet();
		// largest offset with mirroring, top bit of the data must be dropped
		write_reg(mlpbw_pkg::CFG_COLUMN_OFFSET, 8'hff);
		write_reg(mlpbw_pkg::CFG_MIRROR_COLUMNS, 8'h01);
		send_item(mlpbw_pkg::item_t'{8'hff, 8'h11, 10'd0, 7'd0});
		send_item(mlpbw_pkg::item_t'{8'hff, 8'h22, 10'd127, 7'd7});
		send_item(mlpbw_pkg::item_t'{8'hcc, 8'h33, 10'd1023, 7'd127});
		wait_quiet();
		// only bit 0 counts for mirror, only 7 bits for the offset
		write_reg(mlpbw_pkg::CFG_MIRROR_COLUMNS, 8'hfe);
		write_reg(mlpbw_pkg::CFG_COLUMN_OFFSET, 8'h80);
		send_item(mlpbw_pkg::item_t'{8'hff, 8'h44, 10'd127, 7'd0});
		wait_quiet();
		// writes past the register list leave everything alone
		write_reg(CFG_SPARE_A, 8'hff);
		write_reg(CFG_SPARE_B, 8'h5a);
		send_item(mlpbw_pkg::item_t'{8'h0f, 8'hf0, 10'd600, 7'd90});
		send_item(mlpbw_pkg::item_t'{8'hff, 8'hff, 10'd512, 7'd64});
		send_item(mlpbw_pkg::item_t'{8'h3c, 8'hc3, 10'd127, 7'd7});
		wait_quiet();
	endtask

	// random writes under a series of register settings, extremes first
	task automatic test_random_settings(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			if (p == 0) begin
				write_reg(mlpbw_pkg::CFG_COLUMN_OFFSET, 8'h00);
				write_reg(mlpbw_pkg::CFG_MIRROR_COLUMNS, 8'h00);
			end else if (p == 1) begin
				write_reg(mlpbw_pkg::CFG_COLUMN_OFFSET, 8'h7f);
				write_reg(mlpbw_pkg::CFG_MIRROR_COLUMNS, 8'h01);
			end else begin
				write_reg(mlpbw_pkg::CFG_COLUMN_OFFSET, 8'($urandom));
				write_reg(mlpbw_pkg::CFG_MIRROR_COLUMNS, 8'($urandom));
				if ($urandom_range(0, 3) == 0)
					write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
						8'($urandom));
			end
			for (int n = 0; n < per_phase; n++)
				send_item(random_item());
			wait_quiet();
		end
	endtask

	// a stretch with no sender gaps, one write taken every time busy drops
	task automatic test_full_rate(input int count);
		write_reg(mlpbw_pkg::CFG_COLUMN_OFFSET, 8'($urandom));
		write_reg(mlpbw_pkg::CFG_MIRROR_COLUMNS, 8'($urandom));
		no_idle = 1'b1;
		for (int n = 0; n < count; n++)
			send_item(random_item());
		no_idle = 1'b0;
		wait_quiet();
	endtask

	// compare every bus beat with the oldest owed one
	always @(posedge clk) begin
		mlpbw_pkg::result_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (pending_beats.size() == 0) begin
				$error("bus beat with nothing owed: bus_byte %0h is_data %0b last %0b",
					result.bus_byte, result.is_data, result.last);
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				if (result.bus_byte !== want.bus_byte) begin
					$error("bus_byte: expected %0h, actual %0h", want.bus_byte,
						result.bus_byte);
					mismatches++;
				end
				if (result.is_data !== want.is_data) begin
					$error("is_data: expected %0b, actual %0b", want.is_data,
						result.is_data);
					mismatches++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, result.last);
					mismatches++;
				end
			end
		end
	end

	// hang detector, any accepted beat on any channel restarts the count
	always @(posedge clk) begin
		if ((start && busy === 1'b0 && arst_n) || result_valid === 1'b1 ||
				(cfg_valid && cfg_ready === 1'b1))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		stall_count = 0;
		no_idle = 1'b0;
		offset_shadow = '0;
		mirror_shadow = 1'b0;
		for (int i = 0; i < STORE_DEPTH; i++)
			frame_shadow[i] = 8'h00;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its store after reset, wait for it to come up
		wait_quiet();

		test_directed_corners();
		test_random_settings(8, 22);
		test_full_rate(24);

		wait_quiet();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== masked_lcd_page_byte_writer.f =====
rtl/mlpbw_pkg.sv
rtl/masked_lcd_page_byte_writer.sv
tb/testbench.sv
